// File: design/go_to_goal_p_controller_assert.svh
// Assertion macros for the go-to-goal controller
`ifndef GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
// consequent holds in the same cycle as the antecedent
`define G2G_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequent holds in the cycle after the antecedent
`define G2G_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: design/g2g_pkg.sv
// Shared types and constants for the go-to-goal controller
`default_nettype none
package g2g_pkg;
   localparam int TABLE_LEN = 24;
   localparam int KINV_Q16 = 39797;
   localparam logic signed [31:0] PI_Q16 = 32'sd205887;
   localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;
   localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;

   localparam logic [2:0] CSR_GOAL_X = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y = 3'd1;
   localparam logic [2:0] CSR_TOL = 3'd2;
   localparam logic [2:0] CSR_DGAIN = 3'd3;
   localparam logic [2:0] CSR_TGAIN = 3'd4;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_VEC,
      BK_COS,
      BK_MUL
   } bk_state_type;

   // work item passed from front to back
   typedef struct packed {
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [18:0] hd;
   } g2g_item_type;

   typedef struct packed {
      logic signed [15:0] forward_speed;
      logic signed [15:0] turn_rate;
      logic at_goal;
   } g2g_result_type;

   function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
      logic signed [31:0] r;
      case (i)
         5'd0: r = 32'sd51472;
         5'd1: r = 32'sd30386;
         5'd2: r = 32'sd16055;
         5'd3: r = 32'sd8150;
         5'd4: r = 32'sd4091;
         5'd5: r = 32'sd2047;
         5'd6: r = 32'sd1024;
         5'd7: r = 32'sd512;
         5'd8: r = 32'sd256;
         5'd9: r = 32'sd128;
         5'd10: r = 32'sd64;
         5'd11: r = 32'sd32;
         5'd12: r = 32'sd16;
         5'd13: r = 32'sd8;
         5'd14: r = 32'sd4;
         5'd15: r = 32'sd2;
         5'd16: r = 32'sd1;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// File: design/go_to_goal_p_controller.sv
// Go-to-goal proportional controller top level
// The back end uses one shared CORDIC and takes a new pose only once the last result is in its output register;
// at goal it skips the cosine pass and the gain multiplies.
// The front stage and a two-entry queue take new poses while the back end works.
// Reset (synchronous) clears the pipeline and restores register defaults.
`default_nettype none
`include "go_to_goal_p_controller_assert.svh"
module go_to_goal_p_controller
   import g2g_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [47:0] req_tdata, // pos_x, pos_y, heading
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [39:0] rsp_tdata, // forward_speed, turn_rate, at_goal, zero pad
   input wire logic csr_we,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_wdata
);
   logic signed [15:0] goal_x_ff, goal_y_ff;
   logic [14:0] tol_ff;
   logic [15:0] dgain_ff, tgain_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   g2g_item_type f_item, q_item;
   g2g_result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= 16'sd0;
         goal_y_ff <= 16'sd0;
         tol_ff <= 15'd205;
         dgain_ff <= 16'd3277;
         tgain_ff <= 16'd8192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GOAL_X: goal_x_ff <= csr_wdata;
            CSR_GOAL_Y: goal_y_ff <= csr_wdata;
            CSR_TOL: tol_ff <= csr_wdata[14:0];
            CSR_DGAIN: dgain_ff <= csr_wdata;
            CSR_TGAIN: tgain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   g2g_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .pos_x(req_tdata[15:0]), .pos_y(req_tdata[31:16]), .heading(req_tdata[47:32]),
      .goal_x(goal_x_ff), .goal_y(goal_y_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   g2g_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   g2g_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .arrive_tolerance(tol_ff), .distance_gain(dgain_ff), .turn_gain(tgain_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {7'd0, res.at_goal, res.turn_rate, res.forward_speed};

   `G2G_ASSERT_IMPL(a_goal_zero, clock, reset, rsp_tvalid && rsp_tdata[32],
      rsp_tdata[31:0] == 32'd0, "at_goal result with nonzero commands")
   `G2G_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `G2G_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid,
      rsp_tdata[39:33] == 7'd0, "padding bits set")
endmodule
`default_nettype wire

// File: design/g2g_front.sv
// Front end: takes pose transfers, forms the position errors and passes the heading on
`default_nettype none
module g2g_front
   import g2g_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic signed [15:0] pos_x,
   input wire logic signed [15:0] pos_y,
   input wire logic signed [15:0] heading,
   input wire logic signed [15:0] goal_x,
   input wire logic signed [15:0] goal_y,
   output logic out_valid,
   input wire logic out_ready,
   output g2g_item_type out_item
);
   logic valid_ff, valid_in;
   g2g_item_type item_ff, item_in;
   logic signed [16:0] dx, dy;

   assign dx = 17'(goal_x) - 17'(pos_x);
   assign dy = 17'(goal_y) - 17'(pos_y);
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in.dx = {dx, 8'd0};
         item_in.dy = {dy, 8'd0};
         item_in.hd = {heading, 3'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;
endmodule
`default_nettype wire

// File: design/g2g_queue.sv
// Two-entry queue between front and back
`default_nettype none
module g2g_queue
   import g2g_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire g2g_item_type in_item,
   output logic out_valid,
   input wire logic out_ready,
   output g2g_item_type out_item
);
   g2g_item_type mem [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_item = mem[rp_ff];

   always_comb begin
      wp_in = push ? !wp_ff : wp_ff;
      rp_in = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wp_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

// File: design/g2g_back.sv
// Back end: shared CORDIC for atan2/magnitude and cosine, gains and saturation
`default_nettype none
module g2g_back
   import g2g_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)(
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire g2g_item_type in_item,
   input wire logic [14:0] arrive_tolerance,
   input wire logic [15:0] distance_gain,
   input wire logic [15:0] turn_gain,
   output logic out_valid,
   input wire logic out_ready,
   output g2g_result_type out_result
);
   localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam logic [4:0] LAST = 5'(NSTEP - 1);

   bk_state_type state_ff, state_in;
   logic [4:0] it_ff, it_in;
   logic [2:0] ph_ff, ph_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [31:0] err_ff, err_in, dist_ff, dist_in;
   logic signed [18:0] hd_ff, hd_in;
   logic neg_ff, neg_in;
   logic signed [63:0] acc_ff, acc_in;
   g2g_result_type pend_ff, pend_in;
   logic ovalid_ff, ovalid_in;
   g2g_result_type res_ff, res_in;

   logic signed [31:0] xs, ys, a, ar, rx, ry;
   logic signed [63:0] prod;
   logic signed [31:0] pa;
   logic signed [31:0] pb;
   logic signed [31:0] dist_new;
   logic signed [31:0] d11;

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) r = 16'sh7fff;
      else if (v < -64'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   assign in_ready = state_ff == BK_IDLE;
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign prod = 64'(pa) * 64'(pb);

   always_comb begin
      a = err_ff;
      if (a > PI_Q16) a = a - TWO_PI_Q16;
      if (a > PI_Q16) a = a - TWO_PI_Q16;
      ar = a;
      if (ar < -PI_Q16) ar = ar + TWO_PI_Q16;
      if (ar < -PI_Q16) ar = ar + TWO_PI_Q16;
   end

   always_comb begin
      rx = 32'(in_item.dx);
      ry = 32'(in_item.dy);
      if (in_item.dx < 0) begin
         if (in_item.dy >= 0) begin
            rx = 32'(in_item.dy);
            ry = -32'(in_item.dx);
         end else begin
            rx = -32'(in_item.dy);
            ry = 32'(in_item.dx);
         end
      end
   end

   always_comb begin
      pa = dist_ff;
      pb = 32'sd0;
      case (ph_ff)
         3'd0: begin pa = x_ff; pb = 32'(KINV_Q16); end
         3'd1: begin
            if (state_ff == BK_VEC) begin
               pa = x_ff; pb = 32'(KINV_Q16);
            end else begin
               pa = dist_ff; pb = x_ff;
            end
         end
         3'd2: begin pa = acc_ff[31:0]; pb = {16'd0, distance_gain}; end
         3'd3: begin pa = err_ff; pb = {16'd0, turn_gain}; end
         default: begin pa = 32'sd0; pb = 32'sd0; end
      endcase
   end

   assign dist_new = 32'((prod + 64'sd32768) >>> 16);
   assign d11 = (dist_new + 32'sd128) >>> 8;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (in_valid) state_in = BK_VEC;
         BK_VEC: if (it_ff == LAST && ph_ff == 3'd1) begin
            state_in = (d11 >= $signed({17'd0, arrive_tolerance})) ? BK_COS : BK_MUL;
         end
         BK_COS: if (it_ff == LAST) state_in = BK_MUL;
         BK_MUL: if (ph_ff == 3'd4 && (!ovalid_ff || out_ready)) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      it_in = it_ff;
      ph_in = ph_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      err_in = err_ff;
      dist_in = dist_ff;
      hd_in = hd_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      pend_in = pend_ff;
      ovalid_in = ovalid_ff && !out_ready;
      res_in = res_ff;
      case (state_ff)
         BK_IDLE: if (in_valid) begin
            x_in = rx;
            y_in = ry;
            z_in = (in_item.dx < 0) ? ((in_item.dy >= 0) ? HALF_PI_Q16 : -HALF_PI_Q16)
                                    : 32'sd0;
            hd_in = in_item.hd;
            it_in = 5'd0;
            ph_in = 3'd0;
         end
         BK_VEC: begin
            if (ph_ff == 3'd0) begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_q16(it_ff);
               end else if (y_ff < 0) begin
                  x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_q16(it_ff);
               end
               if (it_ff == LAST) ph_in = 3'd1;
               else it_in = it_ff + 5'd1;
            end else begin
               dist_in = dist_new;
               err_in = z_ff - 32'(hd_ff);
               it_in = 5'd0;
               ph_in = 3'd0;
               x_in = 32'(KINV_Q16) <<< 14;
               y_in = 32'sd0;
               if (state_in == BK_MUL) begin
                  ph_in = 3'd4;
                  pend_in.forward_speed = 16'sd0;
                  pend_in.turn_rate = 16'sd0;
                  pend_in.at_goal = 1'b1;
               end
            end
         end
         BK_COS: begin
            if (it_ff == 5'd0 && ph_ff == 3'd0) begin
               neg_in = 1'b0;
               z_in = ar;
               if (ar > HALF_PI_Q16) begin z_in = ar - PI_Q16; neg_in = 1'b1; end
               else if (ar < -HALF_PI_Q16) begin z_in = ar + PI_Q16; neg_in = 1'b1; end
               ph_in = 3'd5;
            end else begin
               if (z_ff >= 0) begin
                  x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_q16(it_ff);
               end else begin
                  x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_q16(it_ff);
               end
               if (it_ff == LAST) begin
                  ph_in = 3'd1;
                  if (neg_ff) x_in = -(x_ff + ((z_ff >= 0) ? -ys : ys));
               end else it_in = it_ff + 5'd1;
            end
         end
         BK_MUL: begin
            case (ph_ff)
               3'd1: begin acc_in = (prod + (64'sd1 <<< 29)) >>> 30; ph_in = 3'd2; end
               3'd2: begin acc_in = (prod + (64'sd1 <<< 21)) >>> 22; ph_in = 3'd3; end
               3'd3: begin
                  pend_in.forward_speed = sat16(acc_ff);
                  pend_in.turn_rate = sat16((prod + 64'sd65536) >>> 17);
                  pend_in.at_goal = 1'b0;
                  ph_in = 3'd4;
               end
               3'd4: if (!ovalid_ff || out_ready) begin
                  ovalid_in = 1'b1;
                  res_in = pend_ff;
               end
               default: ph_in = 3'd4;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
      end
      it_ff <= it_in;
      ph_ff <= ph_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      err_ff <= err_in;
      dist_ff <= dist_in;
      hd_ff <= hd_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      pend_ff <= pend_in;
      res_ff <= res_in;
   end

   assign out_valid = ovalid_ff;
   assign out_result = res_ff;
endmodule
`default_nettype wire
